>>> rtl/core/ffpa_pkg.sv
// Shared definitions of the first-fit pool allocator: default parameter values,
// result status codes and the bit layout of the result transfer.
// Depends on nothing; used by the allocator, its port checker and the testbench.
package ffpa_pkg;

   // Default values of the top-level parameters.
   localparam int POOL_BYTES_DEF    = 65536;
   localparam int MAX_FRAGMENTS_DEF = 16;
   localparam int HEADER_BYTES_DEF  = 16;
   localparam int ALIGN_BYTES_DEF   = 8;

   // Result status codes.
   typedef logic [1:0] status_type;
   localparam status_type STATUS_OK        = 2'd0;
   localparam status_type STATUS_NO_FIT    = 2'd1;
   localparam status_type STATUS_NULL_FREE = 2'd2;
   localparam status_type STATUS_LIST_FULL = 2'd3;

   // Register indexes of the configuration port.
   localparam logic REG_POOL_BYTES = 1'b0;

   // Field positions inside the result tdata.
   localparam int RSP_GRANT_LSB   = 0;
   localparam int RSP_COUNT_LSB   = 16;
   localparam int RSP_FREE_LSB    = 21;
   localparam int RSP_LARGE_LSB   = 38;
   localparam int RSP_SMALL_LSB   = 55;
   localparam int RSP_TDATA_WIDTH = 72;

endpackage

>>> rtl/core/first_fit_pool_allocator_unit.sv
// First-fit pool allocator with a bounded free list held in a segment memory.
// Depends on ffpa_pkg for defaults, status codes and the result layout.
//
// The block serves one request at a time and returns one result transfer per request.
// The block takes no new request until it has finished the last one. How long a
// request takes is set by the single read port of the segment memory, which the
// search, the list shift and the statistics pass walk one entry per cycle; it grows with
// the list position of the segment that fits, the number of segments moved up when a
// segment is taken whole, and the list length after the step. A stalled result
// transfer holds the block in its last step until the result register frees.
// Configuration writes are taken only while the block is idle, and after reset and
// after a pool_bytes write the block loads the head segment before it goes idle.
module first_fit_pool_allocator_unit #(
   parameter int POOL_BYTES    = ffpa_pkg::POOL_BYTES_DEF,
   parameter int MAX_FRAGMENTS = ffpa_pkg::MAX_FRAGMENTS_DEF,
   parameter int HEADER_BYTES  = ffpa_pkg::HEADER_BYTES_DEF,
   parameter int ALIGN_BYTES   = ffpa_pkg::ALIGN_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // request_size[16:0], free_address[32:17], zero fill
   input  logic        req_tuser,   // operation: 0 allocate, 1 free
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // granted_address[15:0], fragment_count[20:16],
                                    // free_bytes[37:21], max_segment[54:38],
                                    // min_segment[71:55]
   output logic [1:0]  rsp_tuser,   // status
   // Configuration port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // Derived sizes.
   localparam int STORE_DEPTH = (POOL_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES;
   localparam int IXW         = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int POOL_CEIL   = (POOL_BYTES < 65536) ? POOL_BYTES : 65536;
   localparam int IW          = $clog2(MAX_FRAGMENTS);
   localparam int CNTW        = $clog2(MAX_FRAGMENTS + 1);
   localparam int SUMW        = 17 + CNTW;
   // Reciprocal of the alignment, exact for operands below 2^18.
   localparam int K1          = 24;
   localparam int R1          = ((1 << K1) + ALIGN_BYTES - 1) / ALIGN_BYTES;
   localparam int P1W         = 18 + 25;
   // Reciprocal of the store depth, exact for 16-bit quotients.
   localparam int SDB         = $clog2(STORE_DEPTH + 1);
   localparam int K2          = 16 + SDB;
   localparam longint R2      = ((64'd1 << K2) + STORE_DEPTH - 1) / STORE_DEPTH;
   localparam int R2W         = 18;
   localparam int P2W         = 16 + R2W;
   localparam int P3W         = 16 + 25;

   // Sequencer codes.
   localparam logic [3:0] S_INIT  = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_ALN_A = 4'd2;
   localparam logic [3:0] S_ALN_B = 4'd3;
   localparam logic [3:0] S_SCAN  = 4'd4;
   localparam logic [3:0] S_SHDN  = 4'd5;
   localparam logic [3:0] S_IX_A  = 4'd6;
   localparam logic [3:0] S_IX_B  = 4'd7;
   localparam logic [3:0] S_IX_C  = 4'd8;
   localparam logic [3:0] S_IX_D  = 4'd9;
   localparam logic [3:0] S_STW   = 4'd10;
   localparam logic [3:0] S_SRD   = 4'd11;
   localparam logic [3:0] S_SHUP  = 4'd12;
   localparam logic [3:0] S_HEAD  = 4'd13;
   localparam logic [3:0] S_SPRM  = 4'd14;
   localparam logic [3:0] S_STAT  = 4'd15;

   // Memories: segment list as {start, length}, and the block size store.
   logic [32:0] seg_mem [MAX_FRAGMENTS];
   logic [16:0] bs_mem  [STORE_DEPTH];

   logic [3:0]      state_ff, state_in;
   logic [CNTW-1:0] ptr_ff, ptr_in;
   logic [CNTW-1:0] total_ff, total_in;
   logic [16:0]     pool_ff, pool_in;
   logic            op_ff, op_in;
   logic [16:0]     rsize_ff, rsize_in;
   logic [1:0]      status_ff, status_in;
   logic [15:0]     grant_ff, grant_in;
   logic [17:0]     size_ff, size_in;
   logic [15:0]     st_ff, st_in;
   logic [16:0]     bsval_ff, bsval_in;
   logic [P1W-1:0]  prod1_ff, prod1_in;
   logic [15:0]     q0_ff, q0_in;
   logic [P2W-1:0]  prod2_ff, prod2_in;
   logic [P3W-1:0]  prod3_ff, prod3_in;
   logic [IXW-1:0]  idx_ff, idx_in;
   logic [SUMW-1:0] sum_ff, sum_in;
   logic [16:0]     max_ff, max_in;
   logic [16:0]     min_ff, min_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [71:0]     rsp_data_ff, rsp_data_in;
   logic [1:0]      rsp_user_ff, rsp_user_in;
   logic [32:0]     seg_rdata_ff;
   logic [16:0]     bs_rdata_ff;

   logic            seg_we;
   logic [IW-1:0]   seg_waddr, seg_raddr;
   logic [32:0]     seg_wdata;
   logic            bs_we;

   logic            csr_write;
   logic [16:0]     wr_value;
   logic [17:0]     mul_x;
   logic [17:0]     q1;
   logic [15:0]     q2;
   logic [P3W-1:0]  diff;
   logic [18:0]     need;
   logic [18:0]     rem;
   logic [15:0]     rd_start;
   logic [16:0]     rd_len;
   logic [16:0]     sum_sat;

   // Configuration port.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == ffpa_pkg::REG_POOL_BYTES) ? {15'd0, pool_ff} : 32'd0;

   always_comb begin
      wr_value = csr_pwdata[16:0];
      if (wr_value < 17'd16) begin
         wr_value = 17'd16;
      end else if (32'(wr_value) > POOL_CEIL) begin
         wr_value = 17'(POOL_CEIL);
      end
   end

   // Shared multiply by the alignment reciprocal.
   assign mul_x  = (state_ff == S_ALN_A) ? 18'(rsize_ff) + 18'(ALIGN_BYTES - 1) : {2'd0, st_ff};
   assign q1     = prod1_ff[K1+17:K1];
   assign q2     = 16'(64'(prod2_ff) >> K2);
   assign diff   = P3W'(q0_ff) - prod3_ff;
   assign need   = 19'(size_ff) + 19'(HEADER_BYTES);
   assign rd_start = seg_rdata_ff[32:17];
   assign rd_len   = seg_rdata_ff[16:0];
   assign rem      = 19'(rd_len) - need;
   assign sum_sat  = (sum_ff > SUMW'(17'h1FFFF)) ? 17'h1FFFF : sum_ff[16:0];

   // A configuration write in the idle cycle takes precedence over a request.
   assign req_tready = (state_ff == S_IDLE) && !csr_write;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // Sequencer and datapath next values.
   always_comb begin
      state_in  = state_ff;
      ptr_in    = ptr_ff;
      total_in  = total_ff;
      pool_in   = pool_ff;
      op_in     = op_ff;
      rsize_in  = rsize_ff;
      status_in = status_ff;
      grant_in  = grant_ff;
      size_in   = size_ff;
      st_in     = st_ff;
      bsval_in  = bsval_ff;
      prod1_in  = P1W'(mul_x) * P1W'(R1);
      q0_in     = q0_ff;
      prod2_in  = prod2_ff;
      prod3_in  = prod3_ff;
      idx_in    = idx_ff;
      sum_in    = sum_ff;
      max_in    = max_ff;
      min_in    = min_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      seg_we    = 1'b0;
      seg_waddr = '0;
      seg_wdata = '0;
      seg_raddr = '0;
      bs_we     = 1'b0;

      // The result register empties when its transfer completes.
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_INIT: begin
            seg_we    = 1'b1;
            seg_wdata = {16'd0, pool_ff};
            total_in  = CNTW'(1);
            state_in  = S_IDLE;
         end
         S_IDLE: begin
            if (csr_write && csr_paddr[2] == ffpa_pkg::REG_POOL_BYTES) begin
               pool_in  = wr_value;
               state_in = S_INIT;
            end else if (req_tvalid) begin
               op_in    = req_tuser;
               rsize_in = req_tdata[16:0];
               grant_in = 16'd0;
               if (!req_tuser) begin
                  state_in = S_ALN_A;
               end else if (req_tdata[32:17] == 16'd0) begin
                  status_in = ffpa_pkg::STATUS_NULL_FREE;
                  state_in  = S_SPRM;
               end else if (32'(total_ff) >= MAX_FRAGMENTS) begin
                  status_in = ffpa_pkg::STATUS_LIST_FULL;
                  state_in  = S_SPRM;
               end else begin
                  status_in = ffpa_pkg::STATUS_OK;
                  st_in     = req_tdata[32:17] - 16'(HEADER_BYTES);
                  state_in  = S_IX_A;
               end
            end
         end
         S_ALN_A: begin
            state_in = S_ALN_B;
         end
         S_ALN_B: begin
            // Aligned size, and the first segment read of the search.
            size_in  = 18'(q1 * 18'(ALIGN_BYTES));
            ptr_in   = '0;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            // The read data belongs to list position ptr_ff.
            if (ptr_ff >= total_ff) begin
               status_in = ffpa_pkg::STATUS_NO_FIT;
               state_in  = S_SPRM;
            end else if (19'(rd_len) >= need) begin
               status_in = ffpa_pkg::STATUS_OK;
               st_in     = rd_start;
               grant_in  = rd_start + 16'(HEADER_BYTES);
               state_in  = S_IX_A;
               if (rem > 19'(HEADER_BYTES)) begin
                  // Split: the segment shrinks in place.
                  seg_we    = 1'b1;
                  seg_waddr = ptr_ff[IW-1:0];
                  seg_wdata = {16'(19'(rd_start) + need), rem[16:0]};
                  bsval_in  = need[16:0];
               end else begin
                  // Whole segment: later entries move up by one.
                  bsval_in = rd_len;
                  total_in = total_ff - CNTW'(1);
                  if (ptr_ff + CNTW'(1) < total_ff) begin
                     ptr_in    = ptr_ff + CNTW'(1);
                     seg_raddr = IW'(ptr_ff + CNTW'(1));
                     state_in  = S_SHDN;
                  end
               end
            end else begin
               ptr_in    = ptr_ff + CNTW'(1);
               seg_raddr = IW'(ptr_ff + CNTW'(1));
            end
         end
         S_SHDN: begin
            seg_we    = 1'b1;
            seg_waddr = IW'(ptr_ff - CNTW'(1));
            seg_wdata = seg_rdata_ff;
            if (ptr_ff == total_ff) begin
               state_in = S_IX_A;
            end else begin
               ptr_in    = ptr_ff + CNTW'(1);
               seg_raddr = IW'(ptr_ff + CNTW'(1));
            end
         end
         S_IX_A: begin
            // Store index: block start divided by the alignment, modulo the depth.
            state_in = S_IX_B;
         end
         S_IX_B: begin
            q0_in    = q1[15:0];
            prod2_in = P2W'(q1[15:0]) * P2W'(R2);
            state_in = S_IX_C;
         end
         S_IX_C: begin
            prod3_in = P3W'(q2) * P3W'(STORE_DEPTH);
            state_in = S_IX_D;
         end
         S_IX_D: begin
            idx_in   = diff[IXW-1:0];
            state_in = op_ff ? S_SRD : S_STW;
         end
         S_STW: begin
            bs_we    = 1'b1;
            state_in = S_SPRM;
         end
         S_SRD: begin
            // The recorded size is read here; the list moves down to open the head.
            if (total_ff == '0) begin
               state_in = S_HEAD;
            end else begin
               ptr_in    = total_ff - CNTW'(1);
               seg_raddr = IW'(total_ff - CNTW'(1));
               state_in  = S_SHUP;
            end
         end
         S_SHUP: begin
            seg_we    = 1'b1;
            seg_waddr = IW'(ptr_ff + CNTW'(1));
            seg_wdata = seg_rdata_ff;
            if (ptr_ff == '0) begin
               state_in = S_HEAD;
            end else begin
               ptr_in    = ptr_ff - CNTW'(1);
               seg_raddr = IW'(ptr_ff - CNTW'(1));
            end
         end
         S_HEAD: begin
            seg_we    = 1'b1;
            seg_wdata = {st_ff, bs_rdata_ff};
            total_in  = total_ff + CNTW'(1);
            state_in  = S_SPRM;
         end
         S_SPRM: begin
            ptr_in   = '0;
            sum_in   = '0;
            max_in   = '0;
            min_in   = '0;
            state_in = S_STAT;
         end
         S_STAT: begin
            if (ptr_ff >= total_ff) begin
               // Hold until the result register is free.
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_in = 1'b1;
                  rsp_user_in  = status_ff;
                  rsp_data_in  = {min_ff, max_ff, sum_sat, 5'(total_ff), grant_ff};
                  state_in     = S_IDLE;
               end
            end else begin
               sum_in = sum_ff + SUMW'(rd_len);
               if (rd_len > max_ff) begin
                  max_in = rd_len;
               end
               if (ptr_ff == '0 || rd_len < min_ff) begin
                  min_in = rd_len;
               end
               ptr_in    = ptr_ff + CNTW'(1);
               seg_raddr = IW'(ptr_ff + CNTW'(1));
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

   // Control and datapath registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         pool_ff      <= 17'(POOL_CEIL);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pool_ff      <= pool_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ptr_ff      <= ptr_in;
      total_ff    <= total_in;
      op_ff       <= op_in;
      rsize_ff    <= rsize_in;
      status_ff   <= status_in;
      grant_ff    <= grant_in;
      size_ff     <= size_in;
      st_ff       <= st_in;
      bsval_ff    <= bsval_in;
      prod1_ff    <= prod1_in;
      q0_ff       <= q0_in;
      prod2_ff    <= prod2_in;
      prod3_ff    <= prod3_in;
      idx_ff      <= idx_in;
      sum_ff      <= sum_in;
      max_ff      <= max_in;
      min_ff      <= min_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   // Segment memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (seg_we) begin
         seg_mem[seg_waddr] <= seg_wdata;
      end
      seg_rdata_ff <= seg_mem[seg_raddr];
   end

   // Block size store, addressed by the computed index.
   always_ff @(posedge clock) begin
      if (bs_we) begin
         bs_mem[idx_ff] <= bsval_ff;
      end
      bs_rdata_ff <= bs_mem[idx_ff];
   end

endmodule

>>> rtl/core/ffpa_checker.sv
// Port checker of the first-fit pool allocator, bound to the top level.
// Depends on ffpa_pkg for status codes and the result layout.
module ffpa_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic [2:0]  csr_paddr,
   input logic [31:0] csr_prdata
);

   logic [4:0]  count;
   logic [16:0] free_b;
   logic [16:0] large_b;
   logic [16:0] small_b;
   logic [15:0] grant;

   assign grant   = rsp_tdata[ffpa_pkg::RSP_GRANT_LSB +: 16];
   assign count   = rsp_tdata[ffpa_pkg::RSP_COUNT_LSB +: 5];
   assign free_b  = rsp_tdata[ffpa_pkg::RSP_FREE_LSB +: 17];
   assign large_b = rsp_tdata[ffpa_pkg::RSP_LARGE_LSB +: 17];
   assign small_b = rsp_tdata[ffpa_pkg::RSP_SMALL_LSB +: 17];

   // A stalled result transfer holds its payload.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // Only a successful request reports a granted address.
   a_grant: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ffpa_pkg::STATUS_OK |-> grant == 16'd0)
      else $error("granted address on a failed request");

   // An empty list reports no bytes and no fragment sizes.
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && count == 5'd0 |-> free_b == 17'd0 && large_b == 17'd0 && small_b == 17'd0)
      else $error("statistics of an empty list are not zero");

   // The smallest fragment never exceeds the largest.
   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> small_b <= large_b)
      else $error("smallest fragment above largest");

   // The pool size register always reads within its clamped range.
   a_pool: assert property (@(posedge clock) disable iff (reset)
      csr_paddr[2] == ffpa_pkg::REG_POOL_BYTES |-> csr_prdata >= 32'd16 && csr_prdata <= 32'd65536)
      else $error("pool size out of range");

endmodule

bind first_fit_pool_allocator_unit ffpa_checker u_ffpa_checker (.*);

>>> dv/testbench.sv
// Self-checking testbench for the first-fit pool allocator unit.
// Depends on ffpa_pkg and first_fit_pool_allocator_unit; no files or arguments.
`timescale 1ns / 1ps

// Predicts allocator results and checks them in order of arrival.
class alloc_scoreboard;
   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] grant;
      logic [4:0]  count;
      logic [16:0] free_bytes;
      logic [16:0] largest;
      logic [16:0] smallest;
   } alloc_result_type;

   localparam int HDR = ffpa_pkg::HEADER_BYTES_DEF;
   localparam int ALN = ffpa_pkg::ALIGN_BYTES_DEF;
   localparam int SLOTS = ffpa_pkg::MAX_FRAGMENTS_DEF;
   localparam int DEPTH = (ffpa_pkg::POOL_BYTES_DEF + ALN - 1) / ALN;

   int unsigned      pool_size;
   logic [15:0]      seg_start[SLOTS];
   logic [16:0]      seg_len[SLOTS];
   int unsigned      seg_count;
   logic [16:0]      size_store[DEPTH];
   alloc_result_type pending[$];
   int               errors;

   // Blocks granted and not yet freed, for well-formed frees.
   logic [15:0]   live_blocks[$];

   function void set_pool(int unsigned v);
      v = v & 17'h1ffff;
      if (v < 16) v = 16;
      if (v > 65536) v = 65536;
      pool_size = v;
      foreach (seg_start[i]) begin
         seg_start[i] = 0;
         seg_len[i] = 0;
      end
      seg_len[0] = v;
      seg_count = 1;
      live_blocks.delete();
   endfunction

   function new();
      errors = 0;
      foreach (size_store[i]) size_store[i] = 0;
      set_pool(65536);
   endfunction

   // Notes an accepted request and queues the predicted result.
   function void note_request(bit op_free, int unsigned req_size, logic [15:0] addr);
      alloc_result_type r;
      longint unsigned need, rem, sum;
      logic [15:0] st;
      r = '0;
      if (!op_free) begin
         need = ((longint'(req_size) + ALN - 1) / ALN) * ALN;
         r.status = ffpa_pkg::STATUS_NO_FIT;
         for (int i = 0; i < seg_count; i++) begin
            if (seg_len[i] >= need + HDR) begin
               st = seg_start[i];
               rem = seg_len[i] - need - HDR;
               if (rem > HDR) begin
                  size_store[(st / ALN) % DEPTH] = 17'(need + HDR);
                  seg_start[i] = 16'(st + HDR + need);
                  seg_len[i] = 17'(rem);
               end else begin
                  size_store[(st / ALN) % DEPTH] = seg_len[i];
                  for (int j = i; j + 1 < seg_count; j++) begin
                     seg_start[j] = seg_start[j + 1];
                     seg_len[j] = seg_len[j + 1];
                  end
                  seg_count--;
               end
               r.status = ffpa_pkg::STATUS_OK;
               r.grant = 16'(st + HDR);
               if (r.grant != 0) live_blocks.push_back(r.grant);
               break;
            end
         end
      end else if (addr == 0) begin
         r.status = ffpa_pkg::STATUS_NULL_FREE;
      end else if (seg_count >= SLOTS) begin
         r.status = ffpa_pkg::STATUS_LIST_FULL;
      end else begin
         st = 16'(addr - HDR);
         for (int j = seg_count; j > 0; j--) begin
            seg_start[j] = seg_start[j - 1];
            seg_len[j] = seg_len[j - 1];
         end
         seg_start[0] = st;
         seg_len[0] = size_store[(st / ALN) % DEPTH];
         seg_count++;
         r.status = ffpa_pkg::STATUS_OK;
      end
      sum = 0;
      for (int i = 0; i < seg_count; i++) begin
         sum += seg_len[i];
         if (seg_len[i] > r.largest) r.largest = seg_len[i];
         if (i == 0 || seg_len[i] < r.smallest) r.smallest = seg_len[i];
      end
      r.free_bytes = (sum > 17'h1ffff) ? 17'h1ffff : 17'(sum);
      r.count = 5'(seg_count);
      pending.push_back(r);
   endfunction

   // Compares one result transfer against the oldest prediction.
   function void check_result(logic [71:0] data, logic [1:0] user);
      alloc_result_type want, got;
      got.status = user;
      got.grant = data[ffpa_pkg::RSP_GRANT_LSB +: 16];
      got.count = data[ffpa_pkg::RSP_COUNT_LSB +: 5];
      got.free_bytes = data[ffpa_pkg::RSP_FREE_LSB +: 17];
      got.largest = data[ffpa_pkg::RSP_LARGE_LSB +: 17];
      got.smallest = data[ffpa_pkg::RSP_SMALL_LSB +: 17];
      if (pending.size() == 0) begin
         $display("%0t: unexpected result, actual %h", $time, got);
         errors++;
         return;
      end
      want = pending.pop_front();
      if (got.status != want.status || got.grant != want.grant ||
          got.count != want.count || got.free_bytes != want.free_bytes ||
          got.largest != want.largest || got.smallest != want.smallest) begin
         $display("%0t: mismatch, expected st=%0d ga=%0d n=%0d fb=%0d lg=%0d sm=%0d",
                  $time, want.status, want.grant, want.count, want.free_bytes,
                  want.largest, want.smallest);
         $display("%0t:           actual st=%0d ga=%0d n=%0d fb=%0d lg=%0d sm=%0d",
                  $time, got.status, got.grant, got.count, got.free_bytes,
                  got.largest, got.smallest);
         errors++;
      end
   endfunction
endclass

module testbench;

   localparam int WATCHDOG_LIMIT = 20000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   alloc_scoreboard board;
   int  send_idle_pct;
   int  recv_stall_pct;
   int  hold_off_cycles;
   int  quiet_cycles;

   first_fit_pool_allocator_unit dut (.*);

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // Watchdog: ends the run when no transfer happens for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL first_fit_pool_allocator_unit");
         $finish;
      end
   end

   // Result side: random stalls, plus a long hold-off when requested.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_result(rsp_tdata, rsp_tuser);
   end

   initial begin
      rsp_tready = 0;
      @(negedge clock);
      forever begin
         @(negedge clock);
         if (hold_off_cycles > 0) begin
            rsp_tready <= 0;
            hold_off_cycles--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Writes one register through the setup and access cycles.
   task automatic csr_write(input logic [2:0] addr, input logic [31:0] value);
      csr_psel <= 1;
      csr_pwrite <= 1;
      csr_paddr <= addr;
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
   endtask

   // Offers one request and waits for its transfer. Valid goes low again between two
   // requests.
   task automatic send_request(input bit op_free, input int unsigned size,
                               input logic [15:0] addr);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      req_tvalid <= 1;
      req_tuser <= op_free;
      req_tdata <= {7'd0, addr, size[16:0]};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_request(op_free, size, addr);
      @(negedge clock);
      req_tvalid <= 0;
   endtask

   // Waits until every predicted result has arrived, then lets the block settle.
   task automatic drain();
      while (board.pending.size() != 0) @(negedge clock);
      repeat (64) @(negedge clock);
   endtask

   task automatic set_pool(input int unsigned bytes);
      drain();
      csr_write(3'(4 * ffpa_pkg::REG_POOL_BYTES), bytes);
      board.set_pool(bytes);
   endtask

   // Allocations of random sizes, mostly valid frees of live blocks, sometimes null frees.
   task automatic random_request();
      int pick;
      int unsigned idx;
      pick = $urandom_range(99);
      if (pick < 45) begin
         case ($urandom_range(9))
            0: send_request(0, $urandom_range(131071), 16'($urandom));
            1, 2: send_request(0, $urandom_range(4096), 16'($urandom));
            default: send_request(0, $urandom_range(256), 16'($urandom));
         endcase
      end else if (pick < 92 && board.live_blocks.size() != 0) begin
         idx = $urandom_range(board.live_blocks.size() - 1);
         send_request(1, $urandom, board.live_blocks[idx]);
         board.live_blocks.delete(idx);
      end else begin
         send_request(1, $urandom, 0);
      end
   endtask

   initial begin
      board = new();
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      req_tuser = 0;
      csr_psel = 0;
      csr_penable = 0;
      csr_pwrite = 0;
      csr_paddr = '0;
      csr_pwdata = '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_off_cycles = 0;
      quiet_cycles = 0;
      repeat (2) @(negedge clock);
      reset = 0;
      repeat (4) @(negedge clock);

      // Directed: extremes of sizes, null free, double free, full list.
      send_request(0, 0, 16'hffff);
      send_request(0, 131071, 0);
      send_request(0, 65536, 0);
      send_request(0, 1, 0);
      send_request(0, 7, 0);
      send_request(1, 0, 0);
      send_request(1, 131071, 16'd16);
      send_request(1, 0, 16'd16);
      for (int i = 0; i < 16; i++) send_request(0, 24, 0);
      // The sixteen blocks above start at 64 and lie 40 bytes apart.
      for (int i = 0; i < 14; i++) send_request(1, 0, 16'(80 + 40 * i));

      // Tiny pool: whole-segment take and empty request at the pool end.
      set_pool(5);
      send_request(0, 0, 0);
      send_request(0, 0, 0);
      set_pool(131071);
      set_pool(65536 - 16);
      send_request(0, 65536 - 32, 0);
      set_pool(65536);
      send_request(0, 65536 - 16, 0);
      send_request(0, 0, 0);

      // Random phases across idling patterns and pool sizes.
      for (int phase = 0; phase < 8; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
            default: begin send_idle_pct = 16; recv_stall_pct = 16; end
         endcase
         case (phase)
            1: set_pool(16);
            2: set_pool(1024);
            3: set_pool($urandom_range(16, 65536));
            4: set_pool(300);
            default: set_pool(65536);
         endcase
         if (phase == 2) hold_off_cycles = 400;
         for (int i = 0; i < 135; i++) begin
            random_request();
            // Pause until the block is empty once per phase.
            if (i == 60) while (board.pending.size() != 0) @(negedge clock);
         end
      end

      drain();
      if (board.errors == 0 && board.pending.size() == 0)
         $display("PASS first_fit_pool_allocator_unit");
      else
         $display("FAIL first_fit_pool_allocator_unit");
      $finish;
   end
endmodule
